/* sv/ptzs_pkg.sv */
// Shared types, codes and reset constants for the PTZ send scheduler.
// No dependencies; imported by every other file of the block.
`timescale 1ns / 1ps
`default_nettype none

package ptzs_pkg;

  localparam int unsigned QueueDepthDefault = 6;
  localparam int unsigned CfgDataW          = 16;
  localparam int unsigned CfgIdxW           = 3;
  localparam int unsigned NumAxes           = 4;

  typedef enum logic [2:0] {
    ReqSetMove   = 3'd0,
    ReqSetFocus  = 3'd1,
    ReqStopAll   = 3'd2,
    ReqQueueCmd  = 3'd3,
    ReqTick      = 3'd4,
    ReqSendAck   = 3'd5,
    ReqSendFail  = 3'd6
  } req_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSpeedLimit  = 3'd0,
    CfgNeutralCode = 3'd1,
    CfgRepeatMs    = 3'd2,
    CfgStopRepeat  = 3'd3,
    CfgCameraSel   = 3'd4,
    CfgHelloCode   = 3'd5,
    CfgRxSizeLimit = 3'd6
  } cfg_idx_e;

  localparam logic SendKindMove = 1'b0;
  localparam logic SendKindCmd  = 1'b1;

  typedef struct packed {
    logic [6:0]  speed_limit;
    logic [7:0]  neutral_code;
    logic [15:0] rpt_period;
    logic [1:0]  stop_repeat;
    logic [3:0]  camera_sel;
    logic [7:0]  hello_code;
    logic [15:0] rx_size_limit;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    speed_limit:   7'd49,
    neutral_code:  8'd50,
    rpt_period:    16'd400,
    stop_repeat:   2'd2,
    camera_sel:    4'd0,
    hello_code:    8'd0,
    rx_size_limit: 16'd8200
  };

  // the ring's first slot holds a hello with the reset hello code
  localparam logic [7:0]  BootCode  = 8'd0;
  localparam logic [31:0] BootValue = 32'd0;

  typedef struct packed {
    logic push;
    logic pop;
  } ring_ctrl_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [7:0]  pan_speed;
    logic [7:0]  tilt_speed;
    logic [7:0]  zoom_speed;
    logic [7:0]  focus_speed;
    logic [7:0]  cmd_code;
    logic [31:0] cmd_value;
    logic [31:0] now_ms;
    logic        link_ready;
    logic        fail_cause;
  } in_item_t;

  typedef struct packed {
    logic                      send_valid;
    logic                      send_kind;
    logic [NumAxes-1:0][7:0]   axis_code;
    logic [7:0]                cmd_code;
    logic [31:0]               cmd_value;
    logic [3:0]                camera_index;
    logic [15:0]               hello_rx_size;
    logic                      link_lost;
    logic                      axis_active;
  } res_t;

  function automatic logic [7:0] sat_speed(logic [7:0] v, logic [6:0] lim);
    logic signed [8:0] sv;
    logic signed [8:0] pos;
    logic signed [8:0] neg;
    logic signed [8:0] r;
    sv  = signed'({v[7], v});
    pos = signed'({2'b00, lim});
    neg = -pos;
    if (sv > pos) begin
      r = pos;
    end else if (sv < neg) begin
      r = neg;
    end else begin
      r = sv;
    end
    return r[7:0];
  endfunction

endpackage

`default_nettype wire

/* sv/ptzs_cfg.sv */
// Configuration register file of the PTZ send scheduler.
// Depends on ptzs_pkg (cfg_t, register index codes, reset values).
`timescale 1ns / 1ps
`default_nettype none

module ptzs_cfg (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [ptzs_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [ptzs_pkg::CfgDataW-1:0]        cfg_data_i,
  output ptzs_pkg::cfg_t                       cfg_o
);
  import ptzs_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgSpeedLimit:  cfg_q.speed_limit   <= cfg_data_i[6:0];
        CfgNeutralCode: cfg_q.neutral_code  <= cfg_data_i[7:0];
        CfgRepeatMs:    cfg_q.rpt_period    <= cfg_data_i[15:0];
        CfgStopRepeat:  cfg_q.stop_repeat   <= cfg_data_i[1:0];
        CfgCameraSel:   cfg_q.camera_sel    <= cfg_data_i[3:0];
        CfgHelloCode:   cfg_q.hello_code    <= cfg_data_i[7:0];
        CfgRxSizeLimit: cfg_q.rx_size_limit <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* sv/ptzs_ring.sv */
// Pending command ring; a push into a full ring drops the oldest entry.
// Depends on ptzs_pkg (ring_ctrl_t, boot entry constants).
`timescale 1ns / 1ps
`default_nettype none

module ptzs_ring #(
  parameter int unsigned DEPTH = ptzs_pkg::QueueDepthDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ptzs_pkg::ring_ctrl_t   ctrl_i,
  input  logic [7:0]             code_i,
  input  logic [31:0]            value_i,
  output logic [7:0]             head_code_o,
  output logic [31:0]            head_value_o,
  output logic                   not_empty_o
);
  import ptzs_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = CW + 1;

  logic [7:0]    codes_q  [DEPTH];
  logic [31:0]   values_q [DEPTH];
  logic [PW-1:0] head_q, head_d, head_inc, slot;
  logic [CW-1:0] count_q, count_d;
  logic [SW-1:0] slot_sum;
  logic          boot_q, boot_d;
  logic          full;

  assign full     = (count_q == CW'(DEPTH));
  assign head_inc = (head_q == PW'(DEPTH - 1)) ? '0 : head_q + PW'(1);
  assign slot_sum = SW'(head_q) + SW'(count_q);

  // when full the new entry lands where the dropped oldest one was
  always_comb begin
    if (full) begin
      slot = head_q;
    end else if (slot_sum >= SW'(DEPTH)) begin
      slot = PW'(slot_sum - SW'(DEPTH));
    end else begin
      slot = PW'(slot_sum);
    end
  end

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    boot_d  = boot_q;
    if (ctrl_i.push) begin
      if (full) begin
        head_d = head_inc;
      end else begin
        count_d = count_q + CW'(1);
      end
      if (slot == '0) begin
        boot_d = 1'b0;
      end
    end else if (ctrl_i.pop) begin
      head_d  = head_inc;
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= CW'(1);
      boot_q  <= 1'b1;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      boot_q  <= boot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      codes_q[slot]  <= code_i;
      values_q[slot] <= value_i;
    end
  end

  // slot 0 reads as the boot hello until first written
  assign head_code_o  = (boot_q && head_q == '0) ? BootCode  : codes_q[head_q];
  assign head_value_o = (boot_q && head_q == '0) ? BootValue : values_q[head_q];
  assign not_empty_o  = (count_q != '0);

endmodule

`default_nettype wire

/* sv/ptz_command_send_scheduler_core.sv */
// PTZ command send scheduler: input register, scheduling logic, result register.
// Uses ptzs_pkg, ptzs_cfg and ptzs_ring.
//
// Usage:
//   Requests enter on the input channel (in_valid_i / in_stall_o) with
//   req_type_i and its fields. Every request yields exactly one result on the
//   output channel (out_valid_o / out_stall_i); send_valid_o marks a result
//   that carries a frame (move or queued command).
//   A request passes through the input register, then the result register.
//   Throughput: one request per cycle; the single pass through the scheduling
//   logic between the registers sets that rate unless the receiver stalls.
//   When the receiver stalls, the result register holds and the input register
//   still takes one more request; in_stall_o rises only once both are full.
//   Reset clears all axis state, busy and dirty flags, the stop counter and
//   the send timestamp, restores the register defaults and leaves one hello
//   command pending in the ring. Configuration writes take effect at once
//   and are meant for idle periods.
`timescale 1ns / 1ps
`default_nettype none

module ptz_command_send_scheduler_core #(
  parameter int unsigned QUEUE_DEPTH = ptzs_pkg::QueueDepthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ptzs_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ptzs_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [2:0]                    req_type_i,
  input  logic signed [7:0]             pan_speed_i,
  input  logic signed [7:0]             tilt_speed_i,
  input  logic signed [7:0]             zoom_speed_i,
  input  logic signed [7:0]             focus_speed_i,
  input  logic [7:0]                    cmd_code_i,
  input  logic signed [31:0]            cmd_value_i,
  input  logic [31:0]                   now_ms_i,
  input  logic                          link_ready_i,
  input  logic                          fail_cause_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          send_valid_o,
  output logic                          send_kind_o,
  output logic [7:0]                    pan_code_o,
  output logic [7:0]                    tilt_code_o,
  output logic [7:0]                    zoom_code_o,
  output logic [7:0]                    focus_code_o,
  output logic [7:0]                    out_cmd_code_o,
  output logic signed [31:0]            out_cmd_value_o,
  output logic [3:0]                    camera_index_o,
  output logic [15:0]                   hello_rx_size_o,
  output logic                          link_lost_o,
  output logic                          axis_active_o
);
  import ptzs_pkg::*;

  cfg_t       cfg;
  ring_ctrl_t ring_ctrl;
  logic [7:0]  ring_code;
  logic [31:0] ring_value;
  logic        ring_not_empty;

  in_item_t s1_q;
  logic     s1_valid_q, s1_valid_d;
  logic     take, adv;

  res_t res_q, res_d;
  logic out_valid_q, out_valid_d;

  logic [NumAxes-1:0][7:0] desired_q, desired_d;
  logic [NumAxes-1:0][7:0] confirmed_q, confirmed_d;
  logic        dirty_q, dirty_d;
  logic        busy_q, busy_d;
  logic [31:0] last_q, last_d;
  logic [1:0]  stops_q, stops_d;

  logic [31:0] diff, elapsed;
  logic        moving_now, axes_due, changed, mark_chk;
  logic        move_go, send_cmd;

  ptzs_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  ptzs_ring #(
    .DEPTH (QUEUE_DEPTH)
  ) u_ring (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ring_ctrl),
    .code_i       (s1_q.cmd_code),
    .value_i      (s1_q.cmd_value),
    .head_code_o  (ring_code),
    .head_value_o (ring_value),
    .not_empty_o  (ring_not_empty)
  );

  // handshake: s1 drains into the result register whenever that is free
  assign adv        = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !adv;
  assign take       = in_valid_i && !in_stall_o;
  assign s1_valid_d = take || (s1_valid_q && !adv);
  assign out_valid_d = adv || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_q.req_type    <= req_type_i;
      s1_q.pan_speed   <= pan_speed_i;
      s1_q.tilt_speed  <= tilt_speed_i;
      s1_q.zoom_speed  <= zoom_speed_i;
      s1_q.focus_speed <= focus_speed_i;
      s1_q.cmd_code    <= cmd_code_i;
      s1_q.cmd_value   <= cmd_value_i;
      s1_q.now_ms      <= now_ms_i;
      s1_q.link_ready  <= link_ready_i;
      s1_q.fail_cause  <= fail_cause_i;
    end
    if (adv) begin
      res_q <= res_d;
    end
  end

  // negative elapsed time reads as zero
  assign diff       = s1_q.now_ms - last_q;
  assign elapsed    = diff[31] ? 32'd0 : diff;
  assign moving_now = |desired_q;
  assign axes_due   = dirty_q || (moving_now && (elapsed >= {16'd0, cfg.rpt_period}));

  always_comb begin
    desired_d   = desired_q;
    confirmed_d = confirmed_q;
    dirty_d     = dirty_q;
    busy_d      = busy_q;
    last_d      = last_q;
    stops_d     = stops_q;
    ring_ctrl   = '0;
    res_d       = '0;
    mark_chk    = 1'b0;
    move_go     = 1'b0;
    send_cmd    = 1'b0;

    case (req_e'(s1_q.req_type))
      ReqSetMove: begin
        desired_d[0] = sat_speed(s1_q.pan_speed,  cfg.speed_limit);
        desired_d[1] = sat_speed(s1_q.tilt_speed, cfg.speed_limit);
        desired_d[2] = sat_speed(s1_q.zoom_speed, cfg.speed_limit);
        mark_chk     = 1'b1;
      end
      ReqSetFocus: begin
        desired_d[3] = sat_speed(s1_q.focus_speed, cfg.speed_limit);
        mark_chk     = 1'b1;
      end
      ReqStopAll: begin
        desired_d = '0;
        dirty_d   = 1'b1;
        stops_d   = cfg.stop_repeat;
      end
      ReqQueueCmd: begin
        ring_ctrl.push = adv;
      end
      ReqTick: begin
        if (!busy_q && s1_q.link_ready) begin
          if (stops_q != 2'd0) begin
            move_go = 1'b1;
            stops_d = stops_q - 2'd1;
          end else if (axes_due) begin
            move_go = 1'b1;
          end else if (ring_not_empty) begin
            send_cmd      = 1'b1;
            ring_ctrl.pop = adv;
          end
        end
      end
      ReqSendAck: begin
        busy_d      = 1'b0;
        confirmed_d = desired_q;
        dirty_d     = 1'b0;
      end
      ReqSendFail: begin
        busy_d          = 1'b0;
        dirty_d         = 1'b1;
        res_d.link_lost = !s1_q.fail_cause;
      end
      default: ;
    endcase

    changed = 1'b0;
    for (int i = 0; i < NumAxes; i++) begin
      if (desired_d[i] != confirmed_q[i]) begin
        changed = 1'b1;
      end
    end
    if (mark_chk && changed) begin
      dirty_d = 1'b1;
    end

    if (move_go) begin
      res_d.send_valid   = 1'b1;
      res_d.send_kind    = SendKindMove;
      for (int i = 0; i < NumAxes; i++) begin
        res_d.axis_code[i] = cfg.neutral_code + desired_d[i];
      end
      res_d.camera_index = cfg.camera_sel;
    end
    if (send_cmd) begin
      res_d.send_valid    = 1'b1;
      res_d.send_kind     = SendKindCmd;
      res_d.cmd_code      = ring_code;
      res_d.cmd_value     = ring_value;
      res_d.camera_index  = cfg.camera_sel;
      res_d.hello_rx_size = (ring_code == cfg.hello_code) ? cfg.rx_size_limit : 16'd0;
    end
    if (move_go || send_cmd) begin
      busy_d = 1'b1;
      last_d = s1_q.now_ms;
    end

    res_d.axis_active = |desired_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      desired_q   <= '0;
      confirmed_q <= '0;
      dirty_q     <= 1'b0;
      busy_q      <= 1'b0;
      last_q      <= '0;
      stops_q     <= '0;
    end else if (adv) begin
      desired_q   <= desired_d;
      confirmed_q <= confirmed_d;
      dirty_q     <= dirty_d;
      busy_q      <= busy_d;
      last_q      <= last_d;
      stops_q     <= stops_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign send_valid_o    = res_q.send_valid;
  assign send_kind_o     = res_q.send_kind;
  assign pan_code_o      = res_q.axis_code[0];
  assign tilt_code_o     = res_q.axis_code[1];
  assign zoom_code_o     = res_q.axis_code[2];
  assign focus_code_o    = res_q.axis_code[3];
  assign out_cmd_code_o  = res_q.cmd_code;
  assign out_cmd_value_o = signed'(res_q.cmd_value);
  assign camera_index_o  = res_q.camera_index;
  assign hello_rx_size_o = res_q.hello_rx_size;
  assign link_lost_o     = res_q.link_lost;
  assign axis_active_o   = res_q.axis_active;

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with empty input register");

  a_send_sets_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && res_d.send_valid) |=> busy_q)
    else $error("frame sent but link not marked busy");

  a_busy_blocks_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && busy_q) |-> !res_d.send_valid)
    else $error("frame scheduled while link busy");

  a_stop_countdown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && res_d.send_valid && stops_q != 2'd0) |=> (stops_q == $past(stops_q) - 2'd1))
    else $error("forced stop frame did not count down");

endmodule

`default_nettype wire

/* verif/ptz_command_send_scheduler_check.sv */
`timescale 1ns / 1ps
// Scoreboard for the PTZ send scheduler: follows register writes, predicts the one
// result each accepted request yields and checks the result stream in order.
// Depends on ptzs_pkg.

module ptz_command_send_scheduler_check #(
  parameter int unsigned QUEUE_DEPTH = ptzs_pkg::QueueDepthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ptzs_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ptzs_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          req_valid_i,
  input  logic                          req_stall_i,
  input  ptzs_pkg::in_item_t            req_i,
  input  logic                          res_valid_i,
  input  logic                          res_stall_i,
  input  ptzs_pkg::res_t                res_i,
  output int                            errors_o,
  output int                            outstanding_o
);
  import ptzs_pkg::*;

  cfg_t              cfg;
  logic signed [7:0] want_axes  [NumAxes];
  logic signed [7:0] acked_axes [NumAxes];
  logic              dirty;
  logic              busy;
  logic [31:0]       last_sent_ms;
  logic [1:0]        stops_left;
  logic [7:0]        ring_code  [QUEUE_DEPTH];
  logic [31:0]       ring_value [QUEUE_DEPTH];
  int unsigned       ring_head;
  int unsigned       ring_count;
  res_t              frames_due [$];
  res_t              due;
  int                errors;

  function automatic logic [7:0] limit_speed(logic [7:0] raw);
    int s;
    int lim;
    s   = int'($signed(raw));
    lim = int'(cfg.speed_limit);
    if (s > lim) begin
      s = lim;
    end else if (s < -lim) begin
      s = -lim;
    end
    return s[7:0];
  endfunction

  function automatic logic axes_running();
    logic any;
    int   i;
    any = 1'b0;
    for (i = 0; i < NumAxes; i++) any |= (want_axes[i] != 0);
    return any;
  endfunction

  function automatic void note_changes();
    int i;
    for (i = 0; i < NumAxes; i++) begin
      if (want_axes[i] != acked_axes[i]) dirty = 1'b1;
    end
  endfunction

  function automatic res_t move_frame(logic [31:0] now);
    res_t r;
    int   i;
    r            = '0;
    r.send_valid = 1'b1;
    r.send_kind  = SendKindMove;
    // wire code wraps modulo 256
    for (i = 0; i < NumAxes; i++) r.axis_code[i] = cfg.neutral_code + want_axes[i];
    r.camera_index = cfg.camera_sel;
    busy           = 1'b1;
    last_sent_ms   = now;
    return r;
  endfunction

  function automatic res_t schedule(in_item_t rq);
    res_t        r;
    logic [31:0] gap;
    logic        hurry;
    int unsigned slot;
    int          i;
    r = '0;
    case (rq.req_type)
      ReqSetMove: begin
        want_axes[0] = limit_speed(rq.pan_speed);
        want_axes[1] = limit_speed(rq.tilt_speed);
        want_axes[2] = limit_speed(rq.zoom_speed);
        note_changes();
      end
      ReqSetFocus: begin
        want_axes[3] = limit_speed(rq.focus_speed);
        note_changes();
      end
      ReqStopAll: begin
        for (i = 0; i < NumAxes; i++) want_axes[i] = '0;
        dirty      = 1'b1;
        stops_left = cfg.stop_repeat;
      end
      ReqQueueCmd: begin
        // full ring drops its oldest entry
        if (ring_count >= QUEUE_DEPTH) begin
          ring_head = (ring_head + 1) % QUEUE_DEPTH;
          ring_count--;
        end
        slot             = (ring_head + ring_count) % QUEUE_DEPTH;
        ring_code[slot]  = rq.cmd_code;
        ring_value[slot] = rq.cmd_value;
        ring_count++;
      end
      ReqTick: if (!busy) begin
        gap = rq.now_ms - last_sent_ms;
        if (gap[31]) gap = '0;  // time went backwards
        hurry = dirty || (axes_running() && gap >= 32'(cfg.rpt_period));
        if (stops_left != 0) begin
          if (rq.link_ready) begin
            r = move_frame(rq.now_ms);
            stops_left--;
          end
        end else if (hurry) begin
          if (rq.link_ready) r = move_frame(rq.now_ms);
        end else if (ring_count != 0 && rq.link_ready) begin
          r.send_valid   = 1'b1;
          r.send_kind    = SendKindCmd;
          r.cmd_code     = ring_code[ring_head];
          r.cmd_value    = ring_value[ring_head];
          r.camera_index = cfg.camera_sel;
          if (ring_code[ring_head] == cfg.hello_code) r.hello_rx_size = cfg.rx_size_limit;
          ring_head    = (ring_head + 1) % QUEUE_DEPTH;
          ring_count--;
          busy         = 1'b1;
          last_sent_ms = rq.now_ms;
        end
      end
      ReqSendAck: begin
        busy = 1'b0;
        for (i = 0; i < NumAxes; i++) acked_axes[i] = want_axes[i];
        dirty = 1'b0;
      end
      ReqSendFail: begin
        busy        = 1'b0;
        dirty       = 1'b1;
        r.link_lost = !rq.fail_cause;
      end
      default: ;
    endcase
    r.axis_active = axes_running();
    return r;
  endfunction

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg = CfgReset;
      for (int i = 0; i < NumAxes; i++) begin
        want_axes[i]  = '0;
        acked_axes[i] = '0;
      end
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        ring_code[i]  = '0;
        ring_value[i] = '0;
      end
      ring_code[0]  = BootCode;
      ring_value[0] = BootValue;
      ring_head     = 0;
      ring_count    = 1;
      dirty         = 1'b0;
      busy          = 1'b0;
      last_sent_ms  = '0;
      stops_left    = '0;
      errors        = 0;
      frames_due.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgSpeedLimit:  cfg.speed_limit   = cfg_data_i[6:0];
          CfgNeutralCode: cfg.neutral_code  = cfg_data_i[7:0];
          CfgRepeatMs:    cfg.rpt_period    = cfg_data_i;
          CfgStopRepeat:  cfg.stop_repeat   = cfg_data_i[1:0];
          CfgCameraSel:   cfg.camera_sel    = cfg_data_i[3:0];
          CfgHelloCode:   cfg.hello_code    = cfg_data_i[7:0];
          CfgRxSizeLimit: cfg.rx_size_limit = cfg_data_i;
          default: ;
        endcase
      end
      if (res_valid_i && !res_stall_i) begin
        if (frames_due.size() == 0) begin
          $error("result arrived with no request outstanding");
          errors++;
        end else begin
          due = frames_due.pop_front();
          compare_field("send_valid", 32'(due.send_valid), 32'(res_i.send_valid));
          compare_field("send_kind", 32'(due.send_kind), 32'(res_i.send_kind));
          compare_field("pan_code", 32'(due.axis_code[0]), 32'(res_i.axis_code[0]));
          compare_field("tilt_code", 32'(due.axis_code[1]), 32'(res_i.axis_code[1]));
          compare_field("zoom_code", 32'(due.axis_code[2]), 32'(res_i.axis_code[2]));
          compare_field("focus_code", 32'(due.axis_code[3]), 32'(res_i.axis_code[3]));
          compare_field("out_cmd_code", 32'(due.cmd_code), 32'(res_i.cmd_code));
          compare_field("out_cmd_value", due.cmd_value, res_i.cmd_value);
          compare_field("camera_index", 32'(due.camera_index), 32'(res_i.camera_index));
          compare_field("hello_rx_size", 32'(due.hello_rx_size), 32'(res_i.hello_rx_size));
          compare_field("link_lost", 32'(due.link_lost), 32'(res_i.link_lost));
          compare_field("axis_active", 32'(due.axis_active), 32'(res_i.axis_active));
        end
      end
      if (req_valid_i && !req_stall_i) frames_due.push_back(schedule(req_i));
    end
    errors_o      <= errors;
    outstanding_o <= frames_due.size();
  end

endmodule

/* verif/ptz_command_send_scheduler_core_test.sv */
`timescale 1ns / 1ps
// Top of the PTZ send scheduler testbench: clock, reset, request stimulus,
// register settings and the verdict. Depends on ptzs_pkg, the core and the scoreboard.

module ptz_command_send_scheduler_core_test;
  import ptzs_pkg::*;

  localparam logic [2:0] ReqUnknown = 3'd7;

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  in_item_t            req_bus     = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic                send_valid_o;
  logic                send_kind_o;
  logic [7:0]          pan_code_o;
  logic [7:0]          tilt_code_o;
  logic [7:0]          zoom_code_o;
  logic [7:0]          focus_code_o;
  logic [7:0]          out_cmd_code_o;
  logic [31:0]         out_cmd_value_o;
  logic [3:0]          camera_index_o;
  logic [15:0]         hello_rx_size_o;
  logic                link_lost_o;
  logic                axis_active_o;
  res_t                seen_res;
  int                  errors;
  int                  outstanding;

  logic                steady    = 1'b0;  // no gaps on either side while set
  logic [7:0]          hello_now = CfgReset.hello_code;
  logic [31:0]         clock_ms  = '0;

  ptz_command_send_scheduler_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_bus.req_type),
    .pan_speed_i    (req_bus.pan_speed),
    .tilt_speed_i   (req_bus.tilt_speed),
    .zoom_speed_i   (req_bus.zoom_speed),
    .focus_speed_i  (req_bus.focus_speed),
    .cmd_code_i     (req_bus.cmd_code),
    .cmd_value_i    (req_bus.cmd_value),
    .now_ms_i       (req_bus.now_ms),
    .link_ready_i   (req_bus.link_ready),
    .fail_cause_i   (req_bus.fail_cause),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .send_valid_o   (send_valid_o),
    .send_kind_o    (send_kind_o),
    .pan_code_o     (pan_code_o),
    .tilt_code_o    (tilt_code_o),
    .zoom_code_o    (zoom_code_o),
    .focus_code_o   (focus_code_o),
    .out_cmd_code_o (out_cmd_code_o),
    .out_cmd_value_o(out_cmd_value_o),
    .camera_index_o (camera_index_o),
    .hello_rx_size_o(hello_rx_size_o),
    .link_lost_o    (link_lost_o),
    .axis_active_o  (axis_active_o)
  );

  assign seen_res = {send_valid_o, send_kind_o, focus_code_o, zoom_code_o, tilt_code_o,
                     pan_code_o, out_cmd_code_o, out_cmd_value_o, camera_index_o,
                     hello_rx_size_o, link_lost_o, axis_active_o};

  ptz_command_send_scheduler_check send_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .req_valid_i  (in_valid_i),
    .req_stall_i  (in_stall_o),
    .req_i        (req_bus),
    .res_valid_i  (out_valid_o),
    .res_stall_i  (out_stall_i),
    .res_i        (seen_res),
    .errors_o     (errors),
    .outstanding_o(outstanding)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  always @(posedge clk_i) out_stall_i <= !steady && ($urandom_range(0, 99) < 21);

  function automatic in_item_t mk(logic [2:0] kind, logic [7:0] pan, logic [7:0] tilt,
                                  logic [7:0] zoom, logic [7:0] focus, logic [7:0] code,
                                  logic [31:0] value, logic [31:0] now, logic ready,
                                  logic cause);
    in_item_t it;
    it.req_type    = kind;
    it.pan_speed   = pan;
    it.tilt_speed  = tilt;
    it.zoom_speed  = zoom;
    it.focus_speed = focus;
    it.cmd_code    = code;
    it.cmd_value   = value;
    it.now_ms      = now;
    it.link_ready  = ready;
    it.fail_cause  = cause;
    return it;
  endfunction

  function automatic logic [7:0] modest_speed();
    return 8'(int'($urandom_range(0, 120)) - 60);
  endfunction

  function automatic in_item_t random_request();
    in_item_t    it;
    int unsigned pick;
    int unsigned roll;
    it = mk(3'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
            8'($urandom), $urandom, $urandom, 1'($urandom), 1'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 14) it.req_type = ReqSetMove;
    else if (pick < 22) it.req_type = ReqSetFocus;
    else if (pick < 27) it.req_type = ReqStopAll;
    else if (pick < 41) it.req_type = ReqQueueCmd;
    else if (pick < 79) it.req_type = ReqTick;
    else if (pick < 93) it.req_type = ReqSendAck;
    else if (pick < 98) it.req_type = ReqSendFail;
    else it.req_type = ReqUnknown;
    if ($urandom_range(0, 9) < 7) begin
      it.pan_speed   = modest_speed();
      it.tilt_speed  = modest_speed();
      it.zoom_speed  = modest_speed();
      it.focus_speed = modest_speed();
    end
    if ($urandom_range(0, 9) < 3) it.cmd_code = hello_now;
    if (it.req_type == ReqTick) begin
      roll = $urandom_range(0, 99);
      if (roll < 75) clock_ms += $urandom_range(0, 700);
      else if (roll < 85) clock_ms += $urandom_range(0, 70000);
      else if (roll < 93) clock_ms -= $urandom_range(1, 1000);
      else if (roll < 97) clock_ms = $urandom;
      else clock_ms = 32'hFFFF_FF00 + $urandom_range(0, 255);
      it.now_ms     = clock_ms;
      it.link_ready = ($urandom_range(0, 99) < 85);
    end
    return it;
  endfunction

  // returns in the time step of the edge that took the request
  task automatic issue(input in_item_t it);
    while (!steady && $urandom_range(0, 99) < 21) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_bus    <= it;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic put_reg(cfg_idx_e idx, logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
  endtask

  task automatic load_settings(cfg_t c);
    put_reg(CfgSpeedLimit, 16'(c.speed_limit));
    put_reg(CfgNeutralCode, 16'(c.neutral_code));
    put_reg(CfgRepeatMs, c.rpt_period);
    put_reg(CfgStopRepeat, 16'(c.stop_repeat));
    put_reg(CfgCameraSel, 16'(c.camera_sel));
    put_reg(CfgHelloCode, 16'(c.hello_code));
    put_reg(CfgRxSizeLimit, c.rx_size_limit);
    cfg_we_i  <= 1'b0;
    hello_now = c.hello_code;
  endtask

  initial begin
    cfg_t plan;
    int   phase;
    int   n;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // boot hello goes out first, then busy, move clamping, repeats and stops
    issue(mk(ReqTick, 0, 0, 0, 0, 0, 0, 32'd0, 1'b1, 1'b0));
    issue(mk(ReqTick, 0, 0, 0, 0, 0, 0, 32'd5, 1'b1, 1'b0));
    issue(mk(ReqSendAck, 0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
    issue(mk(ReqSetMove, 8'h7F, 8'h80, 8'd5, 0, 0, 0, 0, 1'b0, 1'b0));
    issue(mk(ReqTick, 0, 0, 0, 0, 0, 0, 32'd50, 1'b0, 1'b0));
    issue(mk(ReqTick, 0, 0, 0, 0, 0, 0, 32'd100, 1'b1, 1'b0));
    issue(mk(ReqSendAck, 0, 0, 0, 0, 0, 0, 0, 1'b1, 1'b1));
    issue(mk(ReqTick, 0, 0, 0, 0, 0, 0, 32'd300, 1'b1, 1'b0));
    issue(mk(ReqTick, 0, 0, 0, 0, 0, 0, 32'd500, 1'b1, 1'b0));
    issue(mk(ReqSendFail, 0, 0, 0, 0, 0, 0, 0, 1'b1, 1'b0));
    issue(mk(ReqSetFocus, 0, 0, 0, 8'h80, 0, 0, 0, 1'b0, 1'b0));
    issue(mk(ReqTick, 0, 0, 0, 0, 0, 0, 32'd600, 1'b1, 1'b0));
    issue(mk(ReqSendFail, 0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b1));
    issue(mk(ReqQueueCmd, 0, 0, 0, 0, 8'h81, 32'h8000_0000, 0, 1'b0, 1'b0));
    issue(mk(ReqQueueCmd, 0, 0, 0, 0, 8'h00, 32'h7FFF_FFFF, 0, 1'b0, 1'b0));
    issue(mk(ReqStopAll, 0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
    issue(mk(ReqTick, 0, 0, 0, 0, 0, 0, 32'd10, 1'b1, 1'b0));  // elapsed negative
    issue(mk(ReqSendAck, 0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
    issue(mk(ReqTick, 0, 0, 0, 0, 0, 0, 32'd20, 1'b1, 1'b0));
    issue(mk(ReqSendAck, 0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
    issue(mk(ReqTick, 0, 0, 0, 0, 0, 0, 32'd30, 1'b1, 1'b0));
    issue(mk(ReqSendAck, 0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
    issue(mk(ReqTick, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 1'b1, 1'b0));
    issue(mk(ReqUnknown, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
             1'b1, 1'b1));
    issue(mk(ReqSendAck, 0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
    settle();

    for (phase = 0; phase < 5; phase++) begin
      plan = CfgReset;
      case (phase)
        1: plan = '{speed_limit: 7'd127, neutral_code: 8'd255, rpt_period: 16'hFFFF,
                    stop_repeat: 2'd3, camera_sel: 4'd15, hello_code: 8'd255,
                    rx_size_limit: 16'hFFFF};
        2: plan = '0;
        3: begin
          plan.speed_limit   = 7'($urandom);
          plan.neutral_code  = 8'($urandom);
          plan.rpt_period    = 16'($urandom_range(0, 2000));
          plan.stop_repeat   = 2'($urandom);
          plan.camera_sel    = 4'($urandom);
          plan.hello_code    = 8'($urandom);
          plan.rx_size_limit = 16'($urandom);
        end
        4: plan = '{speed_limit: 7'd100, neutral_code: 8'd128, rpt_period: 16'd250,
                    stop_repeat: 2'd1, camera_sel: 4'd9, hello_code: 8'h81,
                    rx_size_limit: 16'd1024};
        default: ;
      endcase
      if (phase != 0) load_settings(plan);
      for (n = 0; n < 260; n++) begin
        steady = (phase == 1 && n >= 40 && n < 200);
        if (phase == 3 && n == 130) settle();  // hold requests until the pipe drains
        issue(random_request());
      end
      steady = 1'b0;
      settle();
    end

    if (errors == 0) begin
      $display("ptz_command_send_scheduler_core_test OK");
    end else begin
      $display("ptz_command_send_scheduler_core_test NOT OK");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("ptz_command_send_scheduler_core_test NOT OK");
    $finish;
  end

endmodule
